FILE: rtl/rth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL package
// Widths, the pipeline record and defaults shared by the conversion pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

   localparam int CHAN_W  = 8;   // one color channel
   localparam int FRAC_W  = 16;  // hue, saturation and lightness
   localparam int SUM_W   = CHAN_W + 1;
   localparam int HUE_W   = 11;  // hue numerator and divisor, 6*d <= 1530
   localparam int SAT_W   = CHAN_W; // saturation divisor, never above 255

   localparam int DIV_BITS_PER_STAGE = 2;

   // Record carried down the divider stages
   typedef struct packed {
      logic                grey;
      logic [HUE_W-1:0]    hue_rem;
      logic [HUE_W-1:0]    hue_div;
      logic [FRAC_W-1:0]   hue_q;
      logic [SAT_W-1:0]    sat_rem;
      logic [SAT_W-1:0]    sat_div;
      logic [FRAC_W-1:0]   sat_low;
      logic [FRAC_W-1:0]   sat_q;
      logic [FRAC_W-1:0]   lightness;
      logic [CHAN_W-1:0]   alpha;
   } stage_type;

endpackage

FILE: rtl/rth_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL channels
// Valid/ready channels for pixel beats in and HSL beats out.
// ----------------------------------------------------------------------------
interface rth_req_if;
   import rth_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rth_rsp_if;
   import rth_pkg::*;

   logic              valid;
   logic              ready;
   logic [FRAC_W-1:0] hue;
   logic [FRAC_W-1:0] saturation;
   logic [FRAC_W-1:0] lightness;
   logic [CHAN_W-1:0] alpha_out;

   modport source (output valid, hue, saturation, lightness, alpha_out, input ready);
   modport sink   (input valid, hue, saturation, lightness, alpha_out, output ready);
endinterface

FILE: rtl/rgb_to_hsl_conversion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL conversion
// Pixel stream converter: RGBA beats in, 16-bit HSL plus alpha beats out.
// ----------------------------------------------------------------------------
//  channel    dir   handshake               payload
//  req_chan   in    valid/ready (sink)      red, green, blue, alpha
//  rsp_chan   out   valid/ready (source)    hue, saturation, lightness, alpha_out
//
//  One beat in per clock while the output is not stalled. The pipeline is
//  the front stage, the restoring divider stages that retire BITS_PER_STAGE
//  quotient bits each, and the output register.
//  Synchronous reset clears every stage's valid bit; payload is not reset.
//  A stage holds while its successor is full and stalled; empty stages
//  still fill, so bubbles close up under backpressure.
// ----------------------------------------------------------------------------
module rgb_to_hsl_conversion #(
   parameter int BITS_PER_STAGE = rth_pkg::DIV_BITS_PER_STAGE
) (
   input  logic      clock,
   input  logic      reset,
   rth_req_if.sink   req_chan,
   rth_rsp_if.source rsp_chan
);
   import rth_pkg::*;

   localparam int NUM_STAGES = FRAC_W / BITS_PER_STAGE;

   logic      valid_w [NUM_STAGES+1];
   logic      ready_w [NUM_STAGES+1];
   stage_type data_w  [NUM_STAGES+1];

   logic              out_valid_ff;
   logic [FRAC_W-1:0] hue_ff;
   logic [FRAC_W-1:0] sat_ff;
   logic [FRAC_W-1:0] light_ff;
   logic [CHAN_W-1:0] alpha_ff;
   logic              out_ready;
   stage_type         last;

   rth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (valid_w[0]),
      .out_ready (ready_w[0]),
      .out_data  (data_w[0])
   );

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_div
      rth_div_stage #(
         .BITS_PER_STAGE (BITS_PER_STAGE)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[s]),
         .in_ready  (ready_w[s]),
         .in_data   (data_w[s]),
         .out_valid (valid_w[s+1]),
         .out_ready (ready_w[s+1]),
         .out_data  (data_w[s+1])
      );
   end

   assign out_ready           = !out_valid_ff || rsp_chan.ready;
   assign ready_w[NUM_STAGES] = out_ready;
   assign last                = data_w[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= valid_w[NUM_STAGES];
      end
   end

   // Grey pixels force hue and saturation to zero
   always_ff @(posedge clock) begin
      if (out_ready && valid_w[NUM_STAGES]) begin
         hue_ff   <= last.grey ? '0 : last.hue_q;
         sat_ff   <= last.grey ? '0 : last.sat_q;
         light_ff <= last.lightness;
         alpha_ff <= last.alpha;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.hue        = hue_ff;
   assign rsp_chan.saturation = sat_ff;
   assign rsp_chan.lightness  = light_ff;
   assign rsp_chan.alpha_out  = alpha_ff;

endmodule

FILE: rtl/rth_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL front stage
// Finds max/min, lightness and sets up both divisions; one register stage.
// ----------------------------------------------------------------------------
module rth_front (
   input  logic               clock,
   input  logic               reset,
   rth_req_if.sink            req_chan,
   output logic               out_valid,
   input  logic               out_ready,
   output rth_pkg::stage_type out_data
);
   import rth_pkg::*;

   logic              valid_ff;
   stage_type         data_ff;
   stage_type         data_in;
   logic              ready;

   logic [CHAN_W-1:0] r, g, b;
   logic [CHAN_W-1:0] mx, mn, d;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  den_hi;
   logic [HUE_W-1:0]  d_ext, g_ext, b_ext, r_ext, n;
   logic [SUM_W+CHAN_W-1:0] light_x;

   assign ready          = !valid_ff || out_ready;
   assign req_chan.ready = ready;

   always_comb begin
      r = req_chan.red;
      g = req_chan.green;
      b = req_chan.blue;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      d   = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      den_hi = (SUM_W)'(2 * ((1 << CHAN_W) - 1)) - sum;

      d_ext = {{(HUE_W-CHAN_W){1'b0}}, d};
      r_ext = {{(HUE_W-CHAN_W){1'b0}}, r};
      g_ext = {{(HUE_W-CHAN_W){1'b0}}, g};
      b_ext = {{(HUE_W-CHAN_W){1'b0}}, b};

      // Red wins ties over green, green over blue
      if (mx == r) begin
         n = g_ext - b_ext;
         if (g < b) begin
            n = n + (d_ext << 2) + (d_ext << 1);
         end
      end else if (mx == g) begin
         n = (d_ext << 1) + b_ext - r_ext;
      end else begin
         n = (d_ext << 2) + r_ext - g_ext;
      end

      light_x = {sum, {CHAN_W{1'b0}}} + {{CHAN_W{1'b0}}, sum};

      data_in.grey      = (d == '0);
      data_in.hue_rem   = n;
      data_in.hue_div   = (d_ext << 2) + (d_ext << 1);
      data_in.hue_q     = '0;
      // 65535*d splits into d-1 above bit 16 and -d below it
      data_in.sat_rem   = d - CHAN_W'(1);
      data_in.sat_div   = sum[SUM_W-1] || (sum[CHAN_W-1:0] == '1) ?
                          ((sum == SUM_W'((1 << CHAN_W) - 1)) ? sum[CHAN_W-1:0]
                                                              : den_hi[CHAN_W-1:0])
                          : sum[CHAN_W-1:0];
      data_in.sat_low   = FRAC_W'(0) - {{(FRAC_W-CHAN_W){1'b0}}, d};
      data_in.sat_q     = '0;
      data_in.lightness = light_x[FRAC_W:1];
      data_in.alpha     = req_chan.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && req_chan.valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/rth_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL divider stage
// Retires BITS_PER_STAGE quotient bits of both the hue and saturation divisions.
// ----------------------------------------------------------------------------
module rth_div_stage #(
   parameter int BITS_PER_STAGE = rth_pkg::DIV_BITS_PER_STAGE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rth_pkg::stage_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rth_pkg::stage_type out_data
);
   import rth_pkg::*;

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic [HUE_W:0] hs;
      logic [SAT_W:0] ss;
      logic           hb;
      logic           sb;
      data_in = in_data;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         // Restoring step: shift, compare, subtract
         hs = {data_in.hue_rem, 1'b0};
         hb = (hs >= {1'b0, data_in.hue_div});
         if (hb) begin
            hs = hs - {1'b0, data_in.hue_div};
         end
         data_in.hue_rem = hs[HUE_W-1:0];
         data_in.hue_q   = {data_in.hue_q[FRAC_W-2:0], hb};

         ss = {data_in.sat_rem, data_in.sat_low[FRAC_W-1]};
         sb = (ss >= {1'b0, data_in.sat_div});
         if (sb) begin
            ss = ss - {1'b0, data_in.sat_div};
         end
         data_in.sat_rem = ss[SAT_W-1:0];
         data_in.sat_low = {data_in.sat_low[FRAC_W-2:0], 1'b0};
         data_in.sat_q   = {data_in.sat_q[FRAC_W-2:0], sb};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL conversion testbench
// Streams directed and random RGBA pixels through the converter with random
// gaps on both channels and one long output stall. Every output beat is
// checked field by field against an in-order prediction of hue, saturation,
// lightness and alpha.
// ----------------------------------------------------------------------------
module tb_top;
   import rth_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_PIXELS = 1500;
   localparam int MAX_WAIT      = 17;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_AFTER    = 400;   // output beats before the long stall
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [CHAN_W-1:0] red, green, blue, alpha;
   } pixel_type;

   typedef struct packed {
      logic [FRAC_W-1:0] hue, saturation, lightness;
      logic [CHAN_W-1:0] alpha_out;
   } hsl_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rth_req_if req_chan ();
   rth_rsp_if rsp_chan ();

   rgb_to_hsl_conversion dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pixel_type pending_pixels[$];
   hsl_type   expected_hsl[$];

   int  tx_wait_left = 0;
   int  rx_wait_left = 0;
   bit  tx_burst = 1'b0;
   bit  rx_burst = 1'b0;
   int  pixels_sent = 0;
   int  results_seen = 0;
   int  error_count = 0;
   int  directed_count = 0;
   int  cycle_count = 0;
   bit  timed_out = 1'b0;
   logic hold_off = 1'b0;
   int  hold_left = 0;
   int  beats_out = 0;
   bit  hold_done = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Predict one pixel's HSL result
   function automatic hsl_type compute_hsl(pixel_type px);
      int      r, g, b, hi, lo, sum, span, den, num, hue;
      hsl_type res;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      sum = hi + lo;
      res.lightness = FRAC_W'((sum * 257) / 2);
      res.hue = '0;
      res.saturation = '0;
      res.alpha_out = px.alpha;
      if (hi != lo) begin
         span = hi - lo;
         den = (sum > 255) ? (510 - sum) : sum;
         res.saturation = FRAC_W'((65535 * span) / den);
         // sector pick: red beats green, green beats blue on a tie
         if (hi == r) begin
            num = g - b;
            if (g < b)
               num += 6 * span;
         end else if (hi == g) begin
            num = 2 * span + b - r;
         end else begin
            num = 4 * span + r - g;
         end
         if (num < 0)
            num = 0;
         hue = (65536 * num) / (6 * span);
         res.hue = FRAC_W'((hue > 65535) ? 65535 : hue);
      end
      return res;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
   endfunction

   function automatic logic [CHAN_W-1:0] extreme_level();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int        top, low;
      px.red   = CHAN_W'($urandom);
      px.green = CHAN_W'($urandom);
      px.blue  = CHAN_W'($urandom);
      px.alpha = CHAN_W'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            px.green = px.red;
            px.blue  = px.red;
         end
         1: begin
            // two channels share the maximum
            top = int'($urandom_range(1, 255));
            low = int'($urandom_range(0, top - 1));
            case ($urandom_range(0, 2))
               0: px = '{CHAN_W'(top), CHAN_W'(top), CHAN_W'(low), px.alpha};
               1: px = '{CHAN_W'(low), CHAN_W'(top), CHAN_W'(top), px.alpha};
               default: px = '{CHAN_W'(top), CHAN_W'(low), CHAN_W'(top), px.alpha};
            endcase
         end
         2: begin
            px.red   = extreme_level();
            px.green = extreme_level();
            px.blue  = extreme_level();
         end
         3: begin
            top = int'($urandom_range(0, 253));
            px.red   = CHAN_W'(top + int'($urandom_range(0, 2)));
            px.green = CHAN_W'(top + int'($urandom_range(0, 2)));
            px.blue  = CHAN_W'(top + int'($urandom_range(0, 2)));
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic add_pixel(int r, int g, int b, int a);
      pending_pixels.push_back('{CHAN_W'(r), CHAN_W'(g), CHAN_W'(b), CHAN_W'(a)});
      directed_count++;
   endtask

   task automatic check_field(string name, logic [FRAC_W-1:0] want, logic [FRAC_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Pixel driver
   always @(posedge clock) begin : req_driver
      int        gap;
      pixel_type px;
      if (reset) begin
         req_chan.valid <= 1'b0;
         tx_wait_left <= 0;
      end else if (!(req_chan.valid && !req_chan.ready)) begin
         if (req_chan.valid) begin
            // beat accepted: queue its expected result
            expected_hsl.push_back(compute_hsl('{req_chan.red, req_chan.green,
                                                 req_chan.blue, req_chan.alpha}));
            pixels_sent++;
            if ($urandom_range(0, 39) == 0)
               tx_burst = !tx_burst;
            gap = draw_wait(tx_burst);
         end else begin
            gap = tx_wait_left;
         end
         if (gap == 0 && pending_pixels.size() > 0) begin
            px = pending_pixels.pop_front();
            req_chan.red   <= px.red;
            req_chan.green <= px.green;
            req_chan.blue  <= px.blue;
            req_chan.alpha <= px.alpha;
            req_chan.valid <= 1'b1;
            tx_wait_left <= 0;
         end else begin
            req_chan.valid <= 1'b0;
            tx_wait_left <= (gap > 0) ? gap - 1 : 0;
         end
      end
   end

   // Result monitor and output backpressure
   always @(posedge clock) begin : rsp_monitor
      int      stall;
      hsl_type got, want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_wait_left <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.hue, rsp_chan.saturation, rsp_chan.lightness,
                    rsp_chan.alpha_out};
            results_seen++;
            if (expected_hsl.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got h=%0d s=%0d l=%0d a=%0d",
                        $time, got.hue, got.saturation, got.lightness, got.alpha_out);
            end else begin
               want = expected_hsl.pop_front();
               check_field("hue", want.hue, got.hue);
               check_field("saturation", want.saturation, got.saturation);
               check_field("lightness", want.lightness, got.lightness);
               check_field("alpha_out", FRAC_W'(want.alpha_out), FRAC_W'(got.alpha_out));
            end
            if ($urandom_range(0, 39) == 0)
               rx_burst = !rx_burst;
            stall = draw_wait(rx_burst);
         end else begin
            stall = rx_wait_left;
         end
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            rx_wait_left <= stall;
         end else if (stall == 0) begin
            rsp_chan.ready <= 1'b1;
            rx_wait_left <= 0;
         end else begin
            rsp_chan.ready <= 1'b0;
            rx_wait_left <= stall - 1;
         end
      end
   end

   // One long output stall so the pipeline fills and pushes back on its input
   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 1'b0;
         hold_left <= 0;
         beats_out <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            beats_out <= beats_out + 1;
         if (!hold_done && beats_out >= HOLD_AFTER) begin
            hold_off <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
               hold_off <= 1'b0;
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.red   = '0;
      req_chan.green = '0;
      req_chan.blue  = '0;
      req_chan.alpha = '0;
      rsp_chan.ready = 1'b0;

      add_pixel(0, 0, 0, 0);
      add_pixel(255, 255, 255, 255);
      add_pixel(255, 0, 0, 8'hAA);
      add_pixel(0, 255, 0, 8'h55);
      add_pixel(0, 0, 255, 1);
      add_pixel(255, 255, 0, 254);
      add_pixel(0, 255, 255, 128);
      add_pixel(255, 0, 255, 127);
      add_pixel(128, 128, 128, 0);
      add_pixel(255, 0, 1, 255);      // red on top, green below blue: hue wraps
      add_pixel(1, 0, 0, 0);
      add_pixel(0, 1, 0, 0);
      add_pixel(0, 0, 1, 0);
      add_pixel(255, 254, 254, 8'h0F);
      add_pixel(254, 255, 255, 8'hF0);
      add_pixel(255, 1, 1, 8'h33);
      add_pixel(128, 127, 127, 8'hCC);
      add_pixel(128, 128, 127, 8'h99);
      add_pixel(129, 127, 127, 8'h66);
      add_pixel(200, 100, 100, 17);
      add_pixel(100, 200, 150, 34);
      add_pixel(50, 60, 200, 68);
      add_pixel(10, 10, 200, 200);
      add_pixel(200, 10, 200, 100);
      repeat (RANDOM_PIXELS)
         pending_pixels.push_back(random_pixel());

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            while (pending_pixels.size() != 0 || req_chan.valid || expected_hsl.size() != 0)
               @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            while (cycle_count < CYCLE_LIMIT)
               @(posedge clock);
            timed_out = 1'b1;
         end
      join_any

      if (timed_out)
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_hsl.size());
      $display("Sent %0d pixels (%0d directed), checked %0d results, %0d mismatches",
               pixels_sent, directed_count, results_seen, error_count);
      $display("Covered grey, tied-maximum, hue-wrap and extreme pixels under random stalls");
      if (!timed_out && error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/rth_pkg.sv
rtl/rth_if.sv
rtl/rth_front.sv
rtl/rth_div_stage.sv
rtl/rgb_to_hsl_conversion.sv
dv/tb_top.sv
